// ===== rtl/core/mcra_pkg.sv =====
// ----------------------------------------------------------------------------
// mcra_pkg
// Shared constants for the multichannel running average unit: field widths,
// stream packing, configuration register indexes and parameter defaults.
// ----------------------------------------------------------------------------
package mcra_pkg;

	// parameter defaults
	localparam int CHANNELS_DEF    = 4;
	localparam int MAX_SAMPLES_DEF = 16;

	// item field widths
	localparam int CH_FIELD_W = 2;
	localparam int TIME_W     = 32;
	localparam int CUR_W      = 16;
	localparam int TOTAL_W    = 24;
	localparam int AVG_W      = 16;
	localparam int SAMP_W     = 5;
	localparam int CNT_REG_W  = 3;
	localparam int IVL_W      = 15;
	localparam int IVL_REGS   = 4;

	// stream packing
	localparam int IN_TDATA_W  = 56;
	localparam int OUT_TDATA_W = 24;
	localparam int OUT_TUSER_W = 2;

	// configuration port
	localparam int CFG_INDEX_W = 3;
	localparam int CFG_DATA_W  = 15;

	localparam logic [CFG_INDEX_W-1:0] REG_CHANNEL_COUNT = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_CH0  = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_INTERVAL_CH3  = 3'd4;

	// result flag positions in tuser
	localparam int USER_TAKEN = 0;
	localparam int USER_BAD   = 1;

endpackage

// ===== rtl/core/multichannel_running_average_unit.sv =====
// ----------------------------------------------------------------------------
// multichannel_running_average_unit
// Per-channel restarting running average of signed current readings, with a
// minimum sampling interval per channel. Channel state lives in a small RAM.
// ----------------------------------------------------------------------------
// The unit handles one item at a time. An item on an unregistered channel, or
// one whose interval has not yet elapsed, goes from the check state straight
// to the output state; a taken reading first goes through a restoring divider
// that retires one quotient bit per cycle over the 24-bit total and then
// through the write-back state. The input is ready again as soon as the result
// moves into the output register, which holds it until the sink takes it.
// Channel state is read from and written back to a synchronous RAM;
// entries never written since reset read as zero through per-entry valid bits.
module multichannel_running_average_unit
	import mcra_pkg::*;
#(
	parameter int CHANNELS    = CHANNELS_DEF,
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	// configuration write port
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	// input items
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // channel, now_ms, current_ma
	// result items
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // average_ma, samples_in_average
	output logic [OUT_TUSER_W-1:0] m_tuser   // taken, bad_channel
);

	localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DEPTH   = 2 ** CH_W;
	localparam int TALLY_W = $clog2(MAX_SAMPLES + 1);
	localparam int STEP_W  = $clog2(TOTAL_W);
	localparam logic [CNT_REG_W-1:0] USED_MAX  = CNT_REG_W'(CHANNELS);
	localparam logic [TALLY_W-1:0]   TALLY_MAX = TALLY_W'(MAX_SAMPLES);
	localparam logic [TALLY_W-1:0]   TALLY_RESTART = TALLY_W'(2);

	typedef struct packed {
		logic [TIME_W-1:0]         last;
		logic [TALLY_W-1:0]        tally;
		logic signed [TOTAL_W-1:0] total;
		logic signed [AVG_W-1:0]   avg;
	} entry_t;

	typedef enum logic [4:0] {
		S_IDLE  = 5'b00001,
		S_CHECK = 5'b00010,
		S_DIV   = 5'b00100,
		S_WB    = 5'b01000,
		S_OUT   = 5'b10000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [CNT_REG_W-1:0] cnt_q;
	logic [IVL_W-1:0]     ivl_q [IVL_REGS];
	logic [1:0]           ivl_slot;

	assign ivl_slot = 2'(cfg_index - REG_INTERVAL_CH0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < IVL_REGS; i++) ivl_q[i] <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_CHANNEL_COUNT) begin
				cnt_q <= cfg_data[CNT_REG_W-1:0];
			end else if (cfg_index >= REG_INTERVAL_CH0 && cfg_index <= REG_INTERVAL_CH3) begin
				ivl_q[ivl_slot] <= cfg_data;
			end
		end
	end

	// input unpacking
	logic                     in_acc;
	logic [CH_FIELD_W-1:0]    in_ch;
	logic [CH_W-1:0]          in_idx;

	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign in_ch    = s_tdata[CH_FIELD_W-1:0];
	assign in_idx   = CH_W'(in_ch);

	// item registers
	logic [CH_FIELD_W-1:0]   ch_q;
	logic [TIME_W-1:0]       now_q;
	logic signed [CUR_W-1:0] cur_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			ch_q  <= in_ch;
			now_q <= s_tdata[CH_FIELD_W +: TIME_W];
			cur_q <= s_tdata[CH_FIELD_W + TIME_W +: CUR_W];
		end
	end

	// channel state memory
	entry_t          mem [DEPTH];
	entry_t          rd_q;
	logic            wr_en;
	entry_t          wr_data;
	logic [CH_W-1:0] ch_idx;

	assign ch_idx = CH_W'(ch_q);

	always_ff @(posedge clk) begin
		if (wr_en) mem[ch_idx] <= wr_data;
		if (in_acc) rd_q <= mem[in_idx];
	end

	// entry valid bits, unwritten entries read as zero
	logic [DEPTH-1:0] valid_q;
	logic             rd_ok_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			if (wr_en) valid_q[ch_idx] <= 1'b1;
			if (in_acc) rd_ok_q <= valid_q[in_idx];
		end
	end

	// check stage: registration, interval, new tally and total
	entry_t                    cur_ent;
	logic [CNT_REG_W-1:0]      used;
	logic                      bad;
	logic [TIME_W-1:0]         elapsed;
	logic                      take;
	logic                      restart;
	logic [TALLY_W-1:0]        tally_nx;
	logic signed [TOTAL_W-1:0] base_total;
	logic signed [TOTAL_W-1:0] total_nx;

	always_comb begin
		cur_ent    = rd_ok_q ? rd_q : '0;
		used       = (cnt_q > USED_MAX) ? USED_MAX : cnt_q;
		bad        = {1'b0, ch_q} >= used;
		elapsed    = now_q - cur_ent.last;
		take       = elapsed >= TIME_W'(ivl_q[ch_q]);
		restart    = !(cur_ent.tally < TALLY_MAX);
		tally_nx   = restart ? TALLY_RESTART : cur_ent.tally + TALLY_W'(1);
		base_total = restart ? TOTAL_W'(cur_ent.avg) : cur_ent.total;
		total_nx   = base_total + TOTAL_W'(cur_q);
	end

	// divider registers
	logic [TALLY_W-1:0]        div_q;
	logic [TALLY_W-1:0]        rem_q;
	logic [TOTAL_W-1:0]        quo_q;
	logic                      neg_q;
	logic signed [TOTAL_W-1:0] total_q;
	logic [STEP_W-1:0]         step_q;

	// one restoring step
	logic [TALLY_W:0]   shifted;
	logic [TALLY_W:0]   trial;
	logic               fits;
	logic [TOTAL_W-1:0] mag;
	logic [TOTAL_W-1:0] quo_signed;

	always_comb begin
		shifted    = {rem_q, quo_q[TOTAL_W-1]};
		trial      = shifted - {1'b0, div_q};
		fits       = shifted >= {1'b0, div_q};
		mag        = total_nx[TOTAL_W-1] ? TOTAL_W'(-total_nx) : TOTAL_W'(total_nx);
		quo_signed = neg_q ? TOTAL_W'(-quo_q) : quo_q;
	end

	// write-back entry
	always_comb begin
		wr_en         = (state_q == S_WB);
		wr_data.last  = now_q;
		wr_data.tally = div_q;
		wr_data.total = total_q;
		wr_data.avg   = quo_signed[AVG_W-1:0];
	end

	// pending result
	logic                  res_taken_q;
	logic                  res_bad_q;
	logic [AVG_W-1:0]      res_avg_q;
	logic [SAMP_W-1:0]     res_samp_q;
	logic [TALLY_W+SAMP_W-1:0] samp_ext;
	logic [TALLY_W+SAMP_W-1:0] samp_ext_nx;

	assign samp_ext    = {{SAMP_W{1'b0}}, cur_ent.tally};
	assign samp_ext_nx = {{SAMP_W{1'b0}}, div_q};

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_acc) state_q <= S_CHECK;
				end
				S_CHECK: begin
					step_q  <= STEP_W'(TOTAL_W - 1);
					state_q <= (!bad && take) ? S_DIV : S_OUT;
				end
				S_DIV: begin
					step_q <= step_q - STEP_W'(1);
					if (step_q == '0) state_q <= S_WB;
				end
				S_WB: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (!m_tvalid || m_tready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_CHECK: begin
				div_q       <= tally_nx;
				total_q     <= total_nx;
				neg_q       <= total_nx[TOTAL_W-1];
				quo_q       <= mag;
				rem_q       <= '0;
				res_taken_q <= 1'b0;
				res_bad_q   <= bad;
				res_avg_q   <= bad ? '0 : cur_ent.avg;
				res_samp_q  <= bad ? '0 : samp_ext[SAMP_W-1:0];
			end
			S_DIV: begin
				rem_q <= fits ? trial[TALLY_W-1:0] : shifted[TALLY_W-1:0];
				quo_q <= {quo_q[TOTAL_W-2:0], fits};
			end
			S_WB: begin
				res_taken_q <= 1'b1;
				res_avg_q   <= quo_signed[AVG_W-1:0];
				res_samp_q  <= samp_ext_nx[SAMP_W-1:0];
			end
			default: begin
			end
		endcase
	end

	// output register
	logic                   out_load;
	logic                   m_tvalid_q;
	logic [OUT_TDATA_W-1:0] m_tdata_q;
	logic [OUT_TUSER_W-1:0] m_tuser_q;

	assign out_load = (state_q == S_OUT) && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			m_tdata_q <= {{(OUT_TDATA_W - AVG_W - SAMP_W){1'b0}}, res_samp_q, res_avg_q};
			m_tuser_q <= {res_bad_q, res_taken_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

// ===== rtl/core/mcra_checker.sv =====
// ----------------------------------------------------------------------------
// mcra_checker
// Port-level checks on the multichannel running average unit, bound to each
// instance of it.
// ----------------------------------------------------------------------------
module mcra_checker
	import mcra_pkg::*;
(
	input logic                   clk,
	input logic                   arst_n,
	input logic                   s_tvalid,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [OUT_TDATA_W-1:0] m_tdata,
	input logic [OUT_TUSER_W-1:0] m_tuser
);

	// a stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result item changed while stalled");

	// only one item in flight
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input ready right after an accepted item");

	// unregistered channel reports nothing taken and zero fields
	a_bad_clean: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[USER_BAD] |-> !m_tuser[USER_TAKEN] && m_tdata == '0)
		else $error("bad channel result carries data");

endmodule

bind multichannel_running_average_unit mcra_checker u_mcra_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
